// File: hw/rtl/utf8enc_pkg.sv
// ----------------------------------------------------------------------------
// utf8enc_pkg
// shared widths, code point limits and request types for the utf-8 encoder
// ----------------------------------------------------------------------------
package utf8enc_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int CAP_WIDTH   = 16;
	localparam int LEN_WIDTH   = 16;
	localparam int WIDE_W      = ((COUNT_WIDTH > CAP_WIDTH) ? COUNT_WIDTH : CAP_WIDTH) + 1;
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	localparam logic [31:0] CP_2BYTE = 32'h0000_0080;
	localparam logic [31:0] CP_3BYTE = 32'h0000_0800;
	localparam logic [31:0] CP_4BYTE = 32'h0001_0000;
	localparam logic [31:0] CP_LIMIT = 32'h0011_0000;
	localparam logic [31:0] SURR_LO  = 32'h0000_D800;
	localparam logic [31:0] SURR_HI  = 32'h0000_DFFF;
	localparam logic [31:0] CP_REPL  = 32'h0000_FFFD;

	localparam logic [7:0] LEAD2 = 8'hC0;
	localparam logic [7:0] LEAD3 = 8'hE0;
	localparam logic [7:0] LEAD4 = 8'hF0;
	localparam logic [7:0] CONT  = 8'h80;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	typedef struct packed {
		logic [3:0][7:0]       seq;
		logic [1:0]            last_idx;
		logic                  done;
		logic                  oos;
		logic [LEN_WIDTH-1:0]  len;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// File: hw/rtl/utf8enc_ifs.sv
// ----------------------------------------------------------------------------
// utf8enc interfaces
// valid/ready channels for code points, output bytes and capacity writes
// ----------------------------------------------------------------------------
interface utf8enc_cp_if import utf8enc_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [31:0] code_point;
	logic        string_start;

	modport source (output valid, code_point, string_start, input ready);
	modport sink   (input valid, code_point, string_start, output ready);
endinterface

interface utf8enc_byte_if import utf8enc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [7:0]           out_byte;
	logic                 run_last;
	logic                 string_done;
	logic                 out_of_space;
	logic [LEN_WIDTH-1:0] string_length;

	modport source (output valid, out_byte, run_last, string_done, out_of_space,
		string_length, input ready);
	modport sink   (input valid, out_byte, run_last, string_done, out_of_space,
		string_length, output ready);
endinterface

interface utf8enc_cfg_if import utf8enc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CAP_WIDTH-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// File: hw/rtl/utf8enc_front.sv
// ----------------------------------------------------------------------------
// utf8enc_front
// accepts code points, tracks string fill, builds up to one byte request each
// ----------------------------------------------------------------------------
module utf8enc_front import utf8enc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	utf8enc_cp_if.sink  points,
	utf8enc_cfg_if.sink cfg,
	input  q_stat_t  q_stat,
	output logic     push,
	output job_t     push_job
);

	logic [CAP_WIDTH-1:0] cap_q;
	count_t               used_q;
	logic                 fin_q;

	logic [WIDE_W-1:0]    cap_w;
	logic [WIDE_W-1:0]    max_w;
	count_t               ecap;
	count_t               used_eff;
	logic                 fin_eff;
	logic [31:0]          cp;
	logic [31:0]          cp3;
	logic [2:0]           n;
	logic [3:0][7:0]      enc;
	logic [COUNT_WIDTH:0] sum;
	logic                 fits;
	logic                 full;
	logic [1:0]           fill_m1;
	logic                 accept;
	logic                 emit;
	count_t               next_used;
	logic                 next_fin;
	job_t                 job;

	assign points.ready = !q_stat.full;
	assign cfg.ready    = 1'b1;
	assign accept       = points.valid && points.ready;
	assign cp           = points.code_point;

	always_comb begin
		cap_w    = WIDE_W'(cap_q);
		max_w    = WIDE_W'({COUNT_WIDTH{1'b1}});
		ecap     = count_t'((cap_w > max_w) ? max_w : cap_w);
		used_eff = points.string_start ? '0 : used_q;
		fin_eff  = points.string_start ? 1'b0 : fin_q;
	end

	// byte sequence for the code point
	always_comb begin
		enc = '0;
		cp3 = cp;
		if (cp < CP_2BYTE) begin
			n      = 3'd1;
			enc[0] = cp[7:0];
		end else if (cp < CP_3BYTE) begin
			n      = 3'd2;
			enc[0] = LEAD2 | {3'b000, cp[10:6]};
			enc[1] = CONT | {2'b00, cp[5:0]};
		end else if (cp >= CP_4BYTE && cp < CP_LIMIT) begin
			n      = 3'd4;
			enc[0] = LEAD4 | {5'b00000, cp[20:18]};
			enc[1] = CONT | {2'b00, cp[17:12]};
			enc[2] = CONT | {2'b00, cp[11:6]};
			enc[3] = CONT | {2'b00, cp[5:0]};
		end else begin
			if (cp >= CP_4BYTE || (cp >= SURR_LO && cp <= SURR_HI)) begin
				cp3 = CP_REPL;
			end
			n      = 3'd3;
			enc[0] = LEAD3 | {4'b0000, cp3[15:12]};
			enc[1] = CONT | {2'b00, cp3[11:6]};
			enc[2] = CONT | {2'b00, cp3[5:0]};
		end
	end

	always_comb begin
		sum     = {1'b0, used_eff} + (COUNT_WIDTH+1)'(n);
		fits    = sum <= {1'b0, ecap};
		full    = sum[COUNT_WIDTH-1:0] == ecap;
		fill_m1 = 2'(ecap - used_eff - count_t'(1));

		next_used    = used_eff;
		next_fin     = fin_eff;
		emit         = 1'b0;
		job.seq      = '0;
		job.last_idx = '0;
		job.done     = 1'b0;
		job.oos      = 1'b0;
		job.len      = '0;
		if (!fin_eff) begin
			if (used_eff >= ecap) begin
				next_fin = 1'b1;
			end else if (cp == '0) begin
				// terminator
				emit     = 1'b1;
				next_fin = 1'b1;
				job.done = 1'b1;
				job.len  = LEN_WIDTH'(used_eff);
			end else if (!fits) begin
				// pad the rest of the string with zeros
				emit         = 1'b1;
				next_used    = ecap;
				next_fin     = 1'b1;
				job.last_idx = fill_m1;
				job.done     = 1'b1;
				job.oos      = 1'b1;
				job.len      = LEN_WIDTH'(ecap);
			end else begin
				emit         = 1'b1;
				next_used    = sum[COUNT_WIDTH-1:0];
				next_fin     = full;
				job.seq      = enc;
				job.last_idx = 2'(n - 3'd1);
				job.done     = full;
				job.len      = full ? LEN_WIDTH'(ecap) : '0;
			end
		end
	end

	assign push     = accept && emit;
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= '1;
			used_q <= '0;
			fin_q  <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				cap_q <= cfg.data;
			end
			if (accept) begin
				used_q <= next_used;
				fin_q  <= next_fin;
			end
		end
	end

endmodule

// File: hw/rtl/utf8enc_queue.sv
// ----------------------------------------------------------------------------
// utf8enc_queue
// short request queue between the front and the byte sequencer
// ----------------------------------------------------------------------------
module utf8enc_queue import utf8enc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  job_t    push_job,
	input  logic    pop,
	output job_t    head,
	output q_stat_t q_stat
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	function automatic logic [QPTR_W-1:0] nxt(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	assign q_stat.full  = cnt_q == (QPTR_W+1)'(QDEPTH);
	assign q_stat.empty = cnt_q == '0;
	assign head         = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= nxt(wr_q);
			end
			if (pop) begin
				rd_q <= nxt(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

// File: hw/rtl/utf8enc_back.sv
// ----------------------------------------------------------------------------
// utf8enc_back
// steps each request one byte a cycle into the output register unless stalled
// ----------------------------------------------------------------------------
module utf8enc_back import utf8enc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  job_t     head,
	input  q_stat_t  q_stat,
	output logic     pop,
	utf8enc_byte_if.source bytes
);

	logic                 valid_q;
	logic [1:0]           idx_q;
	logic [7:0]           byte_q;
	logic                 run_last_q;
	logic                 done_q;
	logic                 oos_q;
	logic [LEN_WIDTH-1:0] len_q;

	logic                 advance;
	logic                 load;
	logic                 last;

	assign advance = !valid_q || bytes.ready;
	assign load    = advance && !q_stat.empty;
	assign last    = idx_q == head.last_idx;
	assign pop     = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (advance) begin
				valid_q <= !q_stat.empty;
			end
			if (load) begin
				idx_q <= last ? '0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q     <= head.seq[idx_q];
			run_last_q <= last;
			done_q     <= last && head.done;
			oos_q      <= last && head.oos;
			len_q      <= last ? head.len : '0;
		end
	end

	assign bytes.valid         = valid_q;
	assign bytes.out_byte      = byte_q;
	assign bytes.run_last      = run_last_q;
	assign bytes.string_done   = done_q;
	assign bytes.out_of_space  = oos_q;
	assign bytes.string_length = len_q;

endmodule

// File: hw/rtl/utf32_to_utf8_encoder.sv
// ----------------------------------------------------------------------------
// utf32_to_utf8_encoder
// path: an accepted item is written into the queue, then its first byte into the output register
// throughput: one output byte a cycle while the receiver is ready, an item giving 1 to 4 bytes,
// set by the byte-wide output register; the front takes an item a cycle while the queue has room
// reset: clears byte count, finished flag and queue; capacity returns to 65535
// ----------------------------------------------------------------------------
module utf32_to_utf8_encoder import utf8enc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	utf8enc_cp_if.sink     points,
	utf8enc_cfg_if.sink    cfg,
	utf8enc_byte_if.source bytes
);

	q_stat_t q_stat;
	logic    push;
	logic    pop;
	job_t    push_job;
	job_t    head;

	utf8enc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.points   (points),
		.cfg      (cfg),
		.q_stat   (q_stat),
		.push     (push),
		.push_job (push_job)
	);

	utf8enc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	utf8enc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.bytes  (bytes)
	);

endmodule

// File: hw/rtl/utf8enc_checker.sv
// ----------------------------------------------------------------------------
// utf8enc_checker
// port-level checks on the output byte stream of the encoder
// ----------------------------------------------------------------------------
module utf8enc_checker import utf8enc_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [7:0]           out_byte,
	input logic                 run_last,
	input logic                 string_done,
	input logic                 out_of_space,
	input logic [LEN_WIDTH-1:0] string_length
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last)
			&& $stable(string_done) && $stable(string_length))
		else $error("stalled output byte changed");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && string_done |-> run_last)
		else $error("string end not on last byte of its request");

	a_oos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_space |-> string_done && out_byte == 8'h00)
		else $error("out of space without zero fill ending the string");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !string_done |-> string_length == '0)
		else $error("length shown on a byte that does not end the string");

endmodule

bind utf32_to_utf8_encoder utf8enc_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (bytes.valid),
	.out_ready     (bytes.ready),
	.out_byte      (bytes.out_byte),
	.run_last      (bytes.run_last),
	.string_done   (bytes.string_done),
	.out_of_space  (bytes.out_of_space),
	.string_length (bytes.string_length)
);

// File: dv/utf32_to_utf8_encoder_test.sv
// ----------------------------------------------------------------------------
// utf32_to_utf8_encoder_test
// drives code points and capacity writes into the encoder, predicts every
// output byte, including fill bytes, string ends and ignored requests, and
// checks the byte stream in order under random sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module utf32_to_utf8_encoder_test;
	import utf8enc_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 320;
	localparam int PHASE_ITEMS   = 40;

	typedef enum logic [1:0] {RX_ALWAYS, RX_PATTERN, RX_RANDOM} rx_mode_t;

	typedef struct {
		logic [7:0]           data;
		logic                 last;
		logic                 fin;
		logic                 oos;
		logic [LEN_WIDTH-1:0] len;
	} enc_byte_t;

	class utf8_string_book;
		logic [CAP_WIDTH-1:0]   capacity;
		logic [COUNT_WIDTH-1:0] used;
		bit                     ended;
		enc_byte_t              pending[$];
		int                     errors;
		int                     bytes_checked;
		int                     strings_closed;
		int                     truncations;

		function new();
			capacity = '1;
			used = '0;
			ended = 0;
			errors = 0;
			bytes_checked = 0;
			strings_closed = 0;
			truncations = 0;
		endfunction

		function void push(logic [7:0] data, bit last, bit fin, bit oos, int len);
			enc_byte_t b;
			b.data = data;
			b.last = last;
			b.fin = fin;
			b.oos = oos;
			b.len = len[LEN_WIDTH-1:0];
			pending.push_back(b);
		endfunction

		// returns the number of bytes the request produces
		function int note(logic [31:0] cp, logic st);
			logic [7:0]  seq [4];
			logic [31:0] c;
			int          n;
			int          room;
			bit          fin;
			if (st) begin
				used = '0;
				ended = 0;
			end
			if (ended)
				return 0;
			if (used >= capacity) begin
				ended = 1;
				return 0;
			end
			c = cp;
			if (c < 32'h80) begin
				if (c == 0) begin
					ended = 1;
					push(8'h00, 1, 1, 0, int'(used));
					return 1;
				end
				seq[0] = c[7:0];
				n = 1;
			end else if (c < 32'h800) begin
				seq[0] = 8'hC0 | {3'b0, c[10:6]};
				seq[1] = 8'h80 | {2'b0, c[5:0]};
				n = 2;
			end else if (c >= 32'h10000 && c < 32'h110000) begin
				seq[0] = 8'hF0 | {5'b0, c[20:18]};
				seq[1] = 8'h80 | {2'b0, c[17:12]};
				seq[2] = 8'h80 | {2'b0, c[11:6]};
				seq[3] = 8'h80 | {2'b0, c[5:0]};
				n = 4;
			end else begin
				if (c >= 32'h10000 || (c >= 32'hD800 && c <= 32'hDFFF))
					c = 32'hFFFD;
				seq[0] = 8'hE0 | {4'b0, c[15:12]};
				seq[1] = 8'h80 | {2'b0, c[11:6]};
				seq[2] = 8'h80 | {2'b0, c[5:0]};
				n = 3;
			end
			room = int'(capacity) - int'(used);
			if (n > room) begin
				for (int i = 0; i < room; i++) begin
					fin = (i == room - 1);
					push(8'h00, fin, fin, fin, fin ? int'(capacity) : 0);
				end
				used = capacity;
				ended = 1;
				return room;
			end
			used = used + n[COUNT_WIDTH-1:0];
			if (used == capacity)
				ended = 1;
			for (int i = 0; i < n; i++) begin
				fin = (i == n - 1) && ended;
				push(seq[i], i == n - 1, fin, 0, fin ? int'(capacity) : 0);
			end
			return n;
		endfunction

		task report(string msg);
			$display("mismatch at byte %0d: %s", bytes_checked, msg);
			errors++;
		endtask

		task check(enc_byte_t got);
			enc_byte_t want;
			bytes_checked++;
			if (pending.size() == 0) begin
				report($sformatf("byte %02h with nothing outstanding", got.data));
				return;
			end
			want = pending.pop_front();
			if (got.data !== want.data)
				report($sformatf("out_byte %02h, predicted %02h", got.data, want.data));
			if (got.last !== want.last)
				report($sformatf("run_last %b, predicted %b", got.last, want.last));
			if (got.fin !== want.fin)
				report($sformatf("string_done %b, predicted %b", got.fin, want.fin));
			if (got.oos !== want.oos)
				report($sformatf("out_of_space %b, predicted %b", got.oos, want.oos));
			if (got.len !== want.len)
				report($sformatf("string_length %0d, predicted %0d", got.len, want.len));
			if (want.fin)
				strings_closed++;
			if (want.oos)
				truncations++;
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	utf8enc_cp_if   points_ch ();
	utf8enc_cfg_if  cfg_ch ();
	utf8enc_byte_if bytes_ch ();

	utf32_to_utf8_encoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.points (points_ch),
		.cfg    (cfg_ch),
		.bytes  (bytes_ch)
	);

	utf8_string_book book = new();

	rx_mode_t   rx_mode = RX_ALWAYS;
	logic [7:0] rx_mask = 8'hFF;
	int         hold_left = 0;
	bit         gaps_on = 0;
	int         burst_left = 0;
	int         items_encoded = 0;
	int         items_sent = 0;
	longint     cycle_count = 0;

	logic [31:0] boundary_points [14] = '{
		32'h0000_007F, 32'h0000_0080, 32'h0000_07FF, 32'h0000_0800,
		32'h0000_D7FF, 32'h0000_D800, 32'h0000_DFFF, 32'h0000_FFFF,
		32'h0001_0000, 32'h0010_FFFF, 32'h0011_0000, 32'hFFFF_FFFF,
		32'h8000_0000, 32'h0000_0000
	};

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("utf32_to_utf8_encoder verification failed");
			$finish;
		end
	end

	// receiver: long hold-off first, then the stall pattern of the phase
	initial begin
		int         slot;
		logic       rdy;
		enc_byte_t  got;
		slot = 0;
		bytes_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rdy = 1'b0;
				hold_left--;
			end else begin
				case (rx_mode)
					RX_ALWAYS: rdy = 1'b1;
					RX_PATTERN: begin
						rdy = rx_mask[slot % 8];
						slot++;
					end
					default: rdy = ($urandom_range(0, 3) != 0);
				endcase
			end
			bytes_ch.ready <= rdy;
			@(posedge clk);
			if (bytes_ch.valid === 1'b1 && bytes_ch.ready === 1'b1) begin
				got.data = bytes_ch.out_byte;
				got.last = bytes_ch.run_last;
				got.fin  = bytes_ch.string_done;
				got.oos  = bytes_ch.out_of_space;
				got.len  = bytes_ch.string_length;
				book.check(got);
			end
		end
	end

	task automatic send_point(input logic [31:0] cp, input logic st);
		int n;
		if (gaps_on && burst_left == 0) begin
			repeat ($urandom_range(1, 8)) begin
				@(negedge clk);
				points_ch.valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
		points_ch.valid        <= 1'b1;
		points_ch.code_point   <= cp;
		points_ch.string_start <= st;
		do @(posedge clk); while (points_ch.ready !== 1'b1);
		items_sent++;
		n = book.note(cp, st);
		if (n > 0)
			items_encoded++;
	endtask

	task automatic settle();
		@(negedge clk);
		points_ch.valid <= 1'b0;
		while (book.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_WIDTH-1:0] cap);
		settle();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= cap;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		book.capacity = cap;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [31:0] random_point();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 38)
			return $urandom_range(1, 32'h7F);
		if (pick < 55)
			return $urandom_range(32'h80, 32'h7FF);
		if (pick < 70)
			return $urandom_range(32'h800, 32'hFFFF);
		if (pick < 82)
			return $urandom_range(32'h10000, 32'h10FFFF);
		if (pick < 87)
			return $urandom_range(32'hD800, 32'hDFFF);
		if (pick < 93)
			return $urandom_range(32'h110000, 32'hFFFFFFFF);
		if (pick < 96)
			return 32'h0;
		return $urandom();
	endfunction

	initial begin
		int                   target;
		int                   phase;
		int                   cap_pick;
		logic [CAP_WIDTH-1:0] cap;
		logic                 st;
		points_ch.valid = 1'b0;
		points_ch.code_point = '0;
		points_ch.string_start = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every length class and its boundaries, replacement and terminator
		write_capacity('1);
		send_point(32'h41, 1'b1);
		foreach (boundary_points[i])
			send_point(boundary_points[i], 1'b0);
		send_point(32'h42, 1'b0);

		// zero capacity
		write_capacity('0);
		send_point(32'h41, 1'b1);
		// exact fit with a four-byte sequence
		write_capacity(CAP_WIDTH'(5));
		send_point(32'h61, 1'b1);
		send_point(32'h1F600, 1'b0);
		// sequence does not fit, two fill bytes
		send_point(32'h61, 1'b1);
		send_point(32'h62, 1'b0);
		send_point(32'h63, 1'b0);
		send_point(32'h20AC, 1'b0);
		// one and three fill bytes
		write_capacity(CAP_WIDTH'(1));
		send_point(32'h80, 1'b1);
		write_capacity(CAP_WIDTH'(3));
		send_point(32'h10000, 1'b1);
		// capacity lowered under the running count
		write_capacity('1);
		send_point(32'h61, 1'b1);
		send_point(32'h62, 1'b0);
		send_point(32'h63, 1'b0);
		write_capacity(CAP_WIDTH'(2));
		send_point(32'h64, 1'b0);
		send_point(32'h65, 1'b1);

		target = items_sent + RANDOM_ITEMS;
		phase = 0;
		while (items_sent < target) begin
			cap_pick = $urandom_range(0, 9);
			if (cap_pick < 5)
				cap = CAP_WIDTH'($urandom_range(1, 16));
			else if (cap_pick < 7)
				cap = CAP_WIDTH'($urandom_range(17, 400));
			else if (cap_pick == 7)
				cap = CAP_WIDTH'($urandom_range(401, 65534));
			else if (cap_pick == 8)
				cap = '1;
			else
				cap = (phase % 3 == 0) ? '0 : CAP_WIDTH'($urandom_range(1, 6));
			write_capacity(cap);
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_mask = 8'($urandom()) | 8'h01;
			gaps_on = ($urandom_range(0, 3) != 0);
			burst_left = 0;
			if (phase % 6 == 1)
				hold_left = $urandom_range(150, 300);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (k == 0)
					st = ($urandom_range(0, 3) != 0);
				else if (book.ended)
					st = ($urandom_range(0, 3) != 0);
				else
					st = ($urandom_range(0, 15) == 0);
				send_point(random_point(), st);
			end
			phase++;
		end
		settle();

		$display("%0d requests sent, %0d of them encoded, over %0d random phases",
			items_sent, items_encoded, phase);
		$display("%0d bytes checked, %0d strings closed, %0d cut short for lack of room",
			book.bytes_checked, book.strings_closed, book.truncations);
		if (book.errors == 0)
			$display("utf32_to_utf8_encoder verification clean");
		else
			$display("utf32_to_utf8_encoder verification failed");
		$finish;
	end

endmodule
